### hdl/tts_pkg.sv
// Shared types, codes and helpers for the timer table scheduler.
// No dependencies; compiled first.
package tts_pkg;

    localparam int TICK_W   = 48;
    localparam int DELAY_W  = 32;
    localparam int ID_W     = 32;
    localparam int HANDLE_W = 16;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ARM_ONESHOT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ARM_PERIODIC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK         = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SERVICE      = 3'd4;

    // response status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FIRED       = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_DUE     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NONE_ACTIVE = 3'd4;

    typedef struct packed {
        logic                active;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  period;
        logic [TICK_W-1:0]   deadline;
    } tts_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } tts_state_t;

    // tick counter plus increment, clamped at the counter's top value
    function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] base,
                                                  input logic [DELAY_W-1:0] inc);
        logic [TICK_W:0] sum;
        sum = {1'b0, base} + {{(TICK_W + 1 - DELAY_W){1'b0}}, inc};
        return sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
    endfunction

endpackage

### hdl/tts_req_if.sv
// Request channel of the timer table scheduler: valid/ready plus request fields.
// No dependencies.
interface tts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] callback_handle;
    logic        callback_valid;
    logic [31:0] delay_ticks;
    logic [31:0] clear_id;

    modport source (output valid, output mode, output callback_handle,
                    output callback_valid, output delay_ticks, output clear_id,
                    input ready);
    modport sink   (input valid, input mode, input callback_handle,
                    input callback_valid, input delay_ticks, input clear_id,
                    output ready);
endinterface

### hdl/tts_rsp_if.sv
// Response channel of the timer table scheduler: valid/ready plus result fields.
// No dependencies.
interface tts_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] timer_id;
    logic [15:0] fired_handle;
    logic        timers_live;

    modport source (output valid, output status, output timer_id,
                    output fired_handle, output timers_live, input ready);
    modport sink   (input valid, input status, input timer_id,
                    input fired_handle, input timers_live, output ready);
endinterface

### hdl/timer_table_scheduler_core.sv
// Timer table scheduler top level: sequencer, timer table memory, result register.
// Depends on tts_pkg, tts_req_if and tts_rsp_if.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req     | in  | mode, callback_handle, callback_valid, delay_ticks, clear_id
//  rsp     | out | status, timer_id, fired_handle, timers_live
//
// Sequence: arm, tick and unknown modes go from idle through exec and back. Clear
//   and service also scan the used slots and finish: the table memory is read
//   one slot per cycle through its single registered read port, so the scan
//   length sets the rate.
// Reset: tick counter, slot count, active count and id counter reset; the table
//   memory is not cleared, since only slots below the slot count are ever examined.
// Stalls: req is taken only while idle; a held response stalls the sequencer
//   only when the next result is ready to be written.
module timer_table_scheduler_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    tts_req_if.sink   req,
    tts_rsp_if.source rsp
);
    import tts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // timer table, one packed entry per slot
    tts_entry_t mem [TABLE_DEPTH];
    tts_entry_t rd_data_reg;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    tts_entry_t wr_data;

    tts_state_t state_reg, state_next;

    // latched request beat
    logic [MODE_W-1:0]   mode_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                cvalid_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [ID_W-1:0]     cid_reg;

    // scheduler state
    logic [TICK_W-1:0] now_reg, now_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [CW-1:0]     act_cnt_reg, act_cnt_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;

    // scan bookkeeping
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic          found_reg, found_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    tts_entry_t    best_reg, best_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                res_any_reg, res_any_next;
    logic                res_load;

    logic               out_free;
    logic               scan_mode;
    logic               arm_mode;
    logic               arm_ok;
    logic [DELAY_W-1:0] eff_delay;
    logic [DELAY_W-1:0] add_inc;
    logic [TICK_W-1:0]  add_sum;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = res_status_reg;
    assign rsp.timer_id     = res_id_reg;
    assign rsp.fired_handle = res_handle_reg;
    assign rsp.timers_live  = res_any_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign scan_mode = (mode_reg == MODE_CLEAR) || (mode_reg == MODE_SERVICE);
    assign arm_mode  = (mode_reg == MODE_ARM_ONESHOT) || (mode_reg == MODE_ARM_PERIODIC);
    assign arm_ok    = cvalid_reg && (used_reg < CW'(TABLE_DEPTH));
    // periodic delay of zero is raised to one tick
    assign eff_delay = ((mode_reg == MODE_ARM_PERIODIC) && (delay_reg == '0))
                       ? DELAY_W'(1) : delay_reg;

    // the one shared saturating adder: arm deadline, tick, periodic reschedule
    always_comb
    begin
        if (state_reg == ST_FINISH)
            add_inc = best_reg.period;
        else if (mode_reg == MODE_TICK)
            add_inc = DELAY_W'(1);
        else
            add_inc = eff_delay;
    end
    assign add_sum = sat_add(now_reg, add_inc);

    assign rd_addr = scan_idx_reg[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (scan_mode)
                    state_next = ST_SCAN;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if ((scan_idx_reg == used_reg) && !pend_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and register next values
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = best_reg;
        res_load        = 1'b0;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_handle_next = res_handle_reg;
        now_next        = now_reg;
        used_next       = used_reg;
        act_cnt_next    = act_cnt_reg;
        next_id_next    = next_id_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                if (scan_mode)
                begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                end
                else if (out_free)
                begin
                    res_load        = 1'b1;
                    res_status_next = STATUS_REFUSED;
                    res_id_next     = '0;
                    res_handle_next = '0;
                    if (arm_mode && arm_ok)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = used_reg[AW-1:0];
                        wr_data.active   = 1'b1;
                        wr_data.id       = next_id_reg;
                        wr_data.handle   = handle_reg;
                        wr_data.period   = (mode_reg == MODE_ARM_PERIODIC) ? eff_delay : '0;
                        wr_data.deadline = add_sum;
                        used_next        = used_reg + CW'(1);
                        act_cnt_next     = act_cnt_reg + CW'(1);
                        next_id_next     = next_id_reg + ID_W'(1);
                        res_status_next  = STATUS_OK;
                        res_id_next      = next_id_reg;
                    end
                    else if (mode_reg == MODE_TICK)
                    begin
                        now_next        = add_sum;
                        res_status_next = STATUS_OK;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle, check each read's data in the cycle after
                if (scan_idx_reg != used_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (mode_reg == MODE_CLEAR)
                    begin
                        // first matching id wins
                        if (!found_reg && (rd_data_reg.id == cid_reg))
                        begin
                            found_next    = 1'b1;
                            best_idx_next = pend_idx_reg;
                            best_next     = rd_data_reg;
                        end
                    end
                    else if (rd_data_reg.active &&
                             (!found_reg || (rd_data_reg.deadline < best_reg.deadline)))
                    begin
                        // strict compare keeps the lowest slot on a tie
                        found_next    = 1'b1;
                        best_idx_next = pend_idx_reg;
                        best_next     = rd_data_reg;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_load        = 1'b1;
                    res_id_next     = '0;
                    res_handle_next = '0;
                    if (mode_reg == MODE_CLEAR)
                    begin
                        res_status_next = STATUS_OK;
                        if (found_reg)
                        begin
                            wr_en          = 1'b1;
                            wr_data.active = 1'b0;
                            if (best_reg.active)
                                act_cnt_next = act_cnt_reg - CW'(1);
                        end
                    end
                    else if (!found_reg)
                    begin
                        res_status_next = STATUS_NONE_ACTIVE;
                    end
                    else if (best_reg.deadline <= now_reg)
                    begin
                        res_status_next = STATUS_FIRED;
                        res_id_next     = best_reg.id;
                        res_handle_next = best_reg.handle;
                        wr_en           = 1'b1;
                        if (best_reg.period != '0)
                        begin
                            wr_data.deadline = add_sum;
                        end
                        else
                        begin
                            wr_data.active = 1'b0;
                            act_cnt_next   = act_cnt_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        res_status_next = STATUS_NOT_DUE;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res_any_next = (act_cnt_next != '0);
        if (res_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            used_reg      <= '0;
            act_cnt_reg   <= '0;
            next_id_reg   <= ID_W'(1);
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            used_reg      <= used_next;
            act_cnt_reg   <= act_cnt_next;
            next_id_reg   <= next_id_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg   <= req.mode;
            handle_reg <= req.callback_handle;
            cvalid_reg <= req.callback_valid;
            delay_reg  <= req.delay_ticks;
            cid_reg    <= req.clear_id;
        end
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_handle_reg <= res_handle_next;
        res_any_reg    <= res_any_next;
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(TABLE_DEPTH))
        else $error("slot count beyond table depth");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act_cnt_reg <= used_reg)
        else $error("active count exceeds used slots");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= used_reg)
        else $error("scan index ran past used slots");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !pend_reg)
        else $error("stale table read pending while idle");

    a_handle_only_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STATUS_FIRED)) |-> (rsp.fired_handle == '0))
        else $error("handle reported on a beat that did not fire");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result overwritten while still held");
`endif

endmodule
